[sv/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, status codes and request types for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Coefficient width (Q8.8 at the default of 16)
    localparam int COEF_W     = 16;
    // Fraction bits added to the quotient (Q16.16 result)
    localparam int FRAC_SHIFT = 16;
    localparam int OUT_W      = 32;

    localparam int PROD_W   = 2 * COEF_W;
    localparam int DISC_W   = 2 * COEF_W + 3;
    localparam int RAD_W    = 2 * COEF_W + 2;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int ROOT_W   = COEF_W + 1;
    localparam int SQ_REM_W = COEF_W + 3;
    localparam int NUM_W    = COEF_W + 3;
    localparam int DVD_W    = NUM_W - 1 + FRAC_SHIFT;
    localparam int DVS_W    = COEF_W + 1;
    // Quotient magnitude widened so that both saturation limits are visible
    localparam int QX_W     = (DVD_W > OUT_W) ? DVD_W + 1 : OUT_W + 1;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ONE   = 2'd1,
        ST_TWO   = 2'd2,
        ST_DEGEN = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_in_req;

    typedef struct packed {
        logic        [1:0]       root_status;
        logic signed [OUT_W-1:0] root_plus;
        logic signed [OUT_W-1:0] root_minus;
    } t_out_req;

    // Sideband that travels alongside the square root pipeline
    typedef struct packed {
        t_status                  status;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
    } t_side;

endpackage

[sv/quadratic_real_root_solver_unit.sv]
// Pipeline order: products, discriminant, square root steps, numerators, divider steps, output register.
// Throughput: one request per cycle unless stalled; the square root and divider pipelines
// hold one bit step per stage. The whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears every stage valid bit.
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_unit
// Real roots of a*x^2 + b*x + c in Q16.16, with root count status.
// ----------------------------------------------------------------------------
module quadratic_real_root_solver_unit import qrs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_res
);

    logic en;

    // Global advance: hold everything while the output request is refused
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: products
    logic                     r1_valid;
    logic signed [PROD_W-1:0] r1_bb;
    logic signed [PROD_W-1:0] r1_ac;
    logic signed [COEF_W-1:0] r1_a;
    logic signed [COEF_W-1:0] r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bb <= i_req.coef_b * i_req.coef_b;
            r1_ac <= i_req.coef_a * i_req.coef_c;
            r1_a  <= i_req.coef_a;
            r1_b  <= i_req.coef_b;
        end
    end

    // Stage 2: discriminant and status
    logic signed [DISC_W-1:0] disc;
    t_status                  n2_status;
    logic                     r2_valid;
    logic [RAD_W-1:0]         r2_rad;
    t_side                    r2_side;

    assign disc = DISC_W'(r1_bb) - (DISC_W'(r1_ac) <<< 2);

    always_comb begin
        priority if (r1_a == '0) begin
            n2_status = ST_DEGEN;
        end else if (disc < 0) begin
            n2_status = ST_NONE;
        end else if (disc == '0) begin
            n2_status = ST_ONE;
        end else begin
            n2_status = ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rad         <= disc[DISC_W-1] ? '0 : disc[RAD_W-1:0];
            r2_side.status <= n2_status;
            r2_side.coef_a <= r1_a;
            r2_side.coef_b <= r1_b;
        end
    end

    // Square root pipeline
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_rad   (r2_rad),
        .i_side  (r2_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 3: numerators as sign and magnitude, divisor |2a|
    logic signed [NUM_W-1:0]  neg_b;
    logic signed [NUM_W-1:0]  s_ext;
    logic signed [NUM_W-1:0]  num_p;
    logic signed [NUM_W-1:0]  num_m;
    logic        [NUM_W-1:0]  mag_p;
    logic        [NUM_W-1:0]  mag_m;
    logic        [COEF_W:0]   mag_a;
    logic                     r3_valid;
    t_status                  r3_status;
    logic                     r3_neg_p;
    logic                     r3_neg_m;
    logic        [DVD_W-1:0]  r3_dvd_p;
    logic        [DVD_W-1:0]  r3_dvd_m;
    logic        [DVS_W-1:0]  r3_dvs;

    assign neg_b = -NUM_W'(sq_side.coef_b);
    assign s_ext = signed'({2'b00, sq_root});
    assign num_p = neg_b + s_ext;
    assign num_m = neg_b - s_ext;
    assign mag_p = num_p[NUM_W-1] ? NUM_W'(-num_p) : NUM_W'(num_p);
    assign mag_m = num_m[NUM_W-1] ? NUM_W'(-num_m) : NUM_W'(num_m);
    assign mag_a = sq_side.coef_a[COEF_W-1] ? (COEF_W+1)'(-(COEF_W+1)'(sq_side.coef_a))
                                            : (COEF_W+1)'(sq_side.coef_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_status <= sq_side.status;
            r3_neg_p  <= num_p[NUM_W-1] ^ sq_side.coef_a[COEF_W-1];
            r3_neg_m  <= num_m[NUM_W-1] ^ sq_side.coef_a[COEF_W-1];
            r3_dvd_p  <= {mag_p[NUM_W-2:0], {FRAC_SHIFT{1'b0}}};
            r3_dvd_m  <= {mag_m[NUM_W-2:0], {FRAC_SHIFT{1'b0}}};
            r3_dvs    <= {mag_a[COEF_W-1:0], 1'b0};
        end
    end

    // Status rides a plain delay line alongside the dividers
    t_status st_line [DVD_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            st_line[0] <= r3_status;
            for (int i = 1; i < DVD_W; i++) begin
                st_line[i] <= st_line[i-1];
            end
        end
    end

    // Dividers for both roots
    logic             dp_valid;
    logic             dp_neg;
    logic [DVD_W-1:0] dp_quot;
    logic             dm_valid;
    logic             dm_neg;
    logic [DVD_W-1:0] dm_quot;

    qrs_div u_div_plus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_neg   (r3_neg_p),
        .i_dvd   (r3_dvd_p),
        .i_dvs   (r3_dvs),
        .o_valid (dp_valid),
        .o_neg   (dp_neg),
        .o_quot  (dp_quot)
    );

    qrs_div u_div_minus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_neg   (r3_neg_m),
        .i_dvd   (r3_dvd_m),
        .i_dvs   (r3_dvs),
        .o_valid (dm_valid),
        .o_neg   (dm_neg),
        .o_quot  (dm_quot)
    );

    // Saturate a signed magnitude to the Q16.16 range
    function automatic logic [OUT_W-1:0] sat_root(input logic neg,
                                                  input logic [DVD_W-1:0] mag);
        logic [QX_W-1:0] q;
        logic [QX_W-1:0] lim;
        q   = QX_W'(mag);
        lim = QX_W'({1'b1, {(OUT_W-1){1'b0}}});
        if (neg) begin
            sat_root = (q >= lim) ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-q);
        end else begin
            sat_root = (q >= lim) ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q);
        end
    endfunction

    // Output register
    t_out_req n_res;
    logic     r_out_valid;
    t_out_req r_out;

    always_comb begin
        n_res.root_status = st_line[DVD_W-1];
        n_res.root_plus   = '0;
        n_res.root_minus  = '0;
        unique case (st_line[DVD_W-1])
            ST_ONE: begin
                n_res.root_plus = sat_root(dp_neg, dp_quot);
            end
            ST_TWO: begin
                n_res.root_plus  = sat_root(dp_neg, dp_quot);
                n_res.root_minus = sat_root(dm_neg, dm_quot);
            end
            default: begin
                n_res.root_plus  = '0;
                n_res.root_minus = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dp_valid && dm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

[sv/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one radicand bit pair per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic                r_valid [SQ_STEPS];
    logic [RAD_W-1:0]    r_rad   [SQ_STEPS];
    logic [ROOT_W-1:0]   r_root  [SQ_STEPS];
    logic [SQ_REM_W-1:0] r_rem   [SQ_STEPS];
    t_side               r_side  [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic                c_valid;
            logic [RAD_W-1:0]    c_rad;
            logic [ROOT_W-1:0]   c_root;
            logic [SQ_REM_W-1:0] c_rem;
            t_side               c_side;
            logic [SQ_REM_W-1:0] rem_sh;
            logic [SQ_REM_W-1:0] trial;
            logic                take;

            // Stage input: port for the first step, previous stage otherwise
            if (k == 0) begin : g_first
                assign c_valid = i_valid;
                assign c_rad   = i_rad;
                assign c_root  = '0;
                assign c_rem   = '0;
                assign c_side  = i_side;
            end else begin : g_next
                assign c_valid = r_valid[k-1];
                assign c_rad   = r_rad[k-1];
                assign c_root  = r_root[k-1];
                assign c_rem   = r_rem[k-1];
                assign c_side  = r_side[k-1];
            end

            // Bring down the next bit pair and try the trial subtrahend
            assign rem_sh = {c_rem[SQ_REM_W-3:0], c_rad[RAD_W-1 -: 2]};
            assign trial  = {c_root, 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= c_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k]  <= {c_rad[RAD_W-3:0], 2'b00};
                    r_root[k] <= {c_root[ROOT_W-2:0], take};
                    r_rem[k]  <= take ? (rem_sh - trial) : rem_sh;
                    r_side[k] <= c_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

[sv/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_neg,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_valid,
    output logic             o_neg,
    output logic [DVD_W-1:0] o_quot
);

    logic             r_valid [DVD_W];
    logic             r_neg   [DVD_W];
    logic [DVD_W-1:0] r_dvd   [DVD_W];
    logic [DVS_W-1:0] r_dvs   [DVD_W];
    logic [DVS_W-1:0] r_rem   [DVD_W];

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++) begin : g_step
            logic             c_valid;
            logic             c_neg;
            logic [DVD_W-1:0] c_dvd;
            logic [DVS_W-1:0] c_dvs;
            logic [DVS_W-1:0] c_rem;
            logic [DVS_W:0]   rem_sh;
            logic [DVS_W:0]   diff;
            logic             take;

            if (k == 0) begin : g_first
                assign c_valid = i_valid;
                assign c_neg   = i_neg;
                assign c_dvd   = i_dvd;
                assign c_dvs   = i_dvs;
                assign c_rem   = '0;
            end else begin : g_next
                assign c_valid = r_valid[k-1];
                assign c_neg   = r_neg[k-1];
                assign c_dvd   = r_dvd[k-1];
                assign c_dvs   = r_dvs[k-1];
                assign c_rem   = r_rem[k-1];
            end

            // Shift in the next dividend bit; quotient bits fill from the right
            assign rem_sh = {c_rem, c_dvd[DVD_W-1]};
            assign diff   = rem_sh - {1'b0, c_dvs};
            assign take   = (rem_sh >= {1'b0, c_dvs});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= c_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[k] <= c_neg;
                    r_dvs[k] <= c_dvs;
                    r_dvd[k] <= {c_dvd[DVD_W-2:0], take};
                    r_rem[k] <= take ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[DVD_W-1];
    assign o_neg   = r_neg[DVD_W-1];
    assign o_quot  = r_dvd[DVD_W-1];

endmodule

[sv/qrs_checker.sv]
// ----------------------------------------------------------------------------
// qrs_port_checks
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_port_checks import qrs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_stall,
    input t_in_req  i_req,
    input logic     o_valid,
    input logic     i_stall,
    input t_out_req o_res
);

    // A refused result request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result request changed while stalled");

    // Input is only held off by a refused result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // No roots or degenerate: both roots zero
    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.root_status == ST_NONE || o_res.root_status == ST_DEGEN)
        |-> o_res.root_plus == '0 && o_res.root_minus == '0)
        else $error("root value without a real root");

    // Single root: minus root zero
    a_one_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.root_status == ST_ONE |-> o_res.root_minus == '0)
        else $error("second root reported for a single root");

endmodule

bind quadratic_real_root_solver_unit qrs_port_checks u_qrs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
